[rtl/core/tomp_pkg.sv]
// Package with the shared constants and types of the outer-product tile multiplier.
`default_nettype none

package tomp_pkg;

    localparam int TILE      = 4;
    localparam int CELLS     = TILE * TILE;
    localparam int SUM_W     = 48;
    localparam int IDX_W     = 2;
    localparam int CELL_IDX_W = 4;
    localparam int CNT_W     = 5;

    typedef struct packed {
        logic capture;
        logic acc_en;
        logic acc_last;
        logic shift;
    } cell_ctl_t;

endpackage

`default_nettype wire

[rtl/core/tomp_cell.sv]
// One multiply-accumulate cell with its slot of the result drain chain.
`default_nettype none

module tomp_cell
    import tomp_pkg::*;
#(
    parameter int DATA_WIDTH = 16
)
(
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire cell_ctl_t                    ctl,
    input  wire logic signed [DATA_WIDTH-1:0] a,
    input  wire logic signed [DATA_WIDTH-1:0] b,
    input  wire logic signed [SUM_W-1:0]      chain_sum_in,
    input  wire logic                         chain_sat_in,
    output logic signed [SUM_W-1:0]           chain_sum_out,
    output logic                              chain_sat_out
);

    localparam int PROD_W = 2 * DATA_WIDTH;
    localparam int EXT_W  = ((PROD_W > SUM_W) ? PROD_W : SUM_W) + 1;
    localparam logic signed [EXT_W-1:0] MAX_EXT =
        {{(EXT_W - SUM_W + 1){1'b0}}, {(SUM_W - 1){1'b1}}};
    localparam logic signed [EXT_W-1:0] MIN_EXT =
        {{(EXT_W - SUM_W + 1){1'b1}}, {(SUM_W - 1){1'b0}}};

    logic signed [PROD_W-1:0] prod_reg;
    logic signed [SUM_W-1:0]  acc_reg;
    logic                     mark_reg;
    logic signed [SUM_W-1:0]  drain_sum_reg;
    logic                     drain_sat_reg;

    logic signed [EXT_W-1:0]  sum_ext;
    logic signed [SUM_W-1:0]  sum_next;
    logic                     ovf;
    logic                     mark_next;

    always_comb
    begin
        sum_ext = EXT_W'(acc_reg) + EXT_W'(prod_reg);
        ovf     = 1'b1;
        if (sum_ext > MAX_EXT)
        begin
            sum_next = MAX_EXT[SUM_W-1:0];
        end
        else if (sum_ext < MIN_EXT)
        begin
            sum_next = MIN_EXT[SUM_W-1:0];
        end
        else
        begin
            sum_next = sum_ext[SUM_W-1:0];
            ovf      = 1'b0;
        end
        mark_next = mark_reg | ovf;
    end

    always_ff @(posedge clk)
    begin
        if (ctl.capture)
        begin
            prod_reg <= a * b;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg  <= '0;
            mark_reg <= 1'b0;
        end
        else if (ctl.acc_en)
        begin
            if (ctl.acc_last)
            begin
                acc_reg  <= '0;
                mark_reg <= 1'b0;
            end
            else
            begin
                acc_reg  <= sum_next;
                mark_reg <= mark_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.acc_en && ctl.acc_last)
        begin
            drain_sum_reg <= sum_next;
            drain_sat_reg <= mark_next;
        end
        else if (ctl.shift)
        begin
            drain_sum_reg <= chain_sum_in;
            drain_sat_reg <= chain_sat_in;
        end
    end

    assign chain_sum_out = drain_sum_reg;
    assign chain_sat_out = drain_sat_reg;

endmodule

`default_nettype wire

[rtl/core/tile_outer_product_matmul.sv]
// Top level of the 4x4 outer-product tile multiplier with sixteen accumulating cells.
// A request brings one column slice of A, one row slice of B and a last-step mark.
// Requests are taken on req_valid while req_stall is low; results leave on res_valid
// while res_stall is low. Each of the sixteen cells multiplies its operand pair into a
// product register and adds it into its 48-bit accumulator in the next cycle, saturating
// at the 48-bit limits with a sticky mark.
// Throughput is one request per cycle while req_stall is low. A last-step request is held
// off while an earlier tile still drains or a last step is still in the product stage.
// When the last step is added, all sixteen sums move into a drain chain that runs
// through the cells, and the accumulators clear. The first result, row 0 column 0,
// is offered once the last step has passed the product register stage and the drain load;
// the chain then shifts one result per cycle while res_stall is low, in row-major order.
// last_result marks row 3 column 3. While res_stall is high the chain holds and requests
// without the last mark are still taken and accumulated for the next tile.
// Reset clears the accumulators, the saturation marks and the drain count.
`default_nettype none

module tile_outer_product_matmul
    import tomp_pkg::*;
#(
    parameter int DATA_WIDTH = 16
)
(
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         req_valid,
    output logic                              req_stall,
    input  wire logic signed [DATA_WIDTH-1:0] a_row0,
    input  wire logic signed [DATA_WIDTH-1:0] a_row1,
    input  wire logic signed [DATA_WIDTH-1:0] a_row2,
    input  wire logic signed [DATA_WIDTH-1:0] a_row3,
    input  wire logic signed [DATA_WIDTH-1:0] b_col0,
    input  wire logic signed [DATA_WIDTH-1:0] b_col1,
    input  wire logic signed [DATA_WIDTH-1:0] b_col2,
    input  wire logic signed [DATA_WIDTH-1:0] b_col3,
    input  wire logic                         last_step,
    output logic                              res_valid,
    input  wire logic                         res_stall,
    output logic [IDX_W-1:0]                  tile_row,
    output logic [IDX_W-1:0]                  tile_col,
    output logic signed [SUM_W-1:0]           sum_value,
    output logic                              saturated,
    output logic                              last_result
);

    logic signed [DATA_WIDTH-1:0] a_op [TILE];
    logic signed [DATA_WIDTH-1:0] b_op [TILE];
    logic signed [SUM_W-1:0]      chain_sum [CELLS+1];
    logic                         chain_sat [CELLS+1];

    logic                p_vld_reg;
    logic                p_last_reg;
    logic [CNT_W-1:0]    cnt_reg;
    logic [CNT_W-1:0]    cnt_next;
    logic                req_acc;
    logic                res_acc;
    logic                load;
    logic [CELL_IDX_W-1:0] out_idx;
    cell_ctl_t           ctl;

    assign a_op[0] = a_row0;
    assign a_op[1] = a_row1;
    assign a_op[2] = a_row2;
    assign a_op[3] = a_row3;
    assign b_op[0] = b_col0;
    assign b_op[1] = b_col1;
    assign b_op[2] = b_col2;
    assign b_op[3] = b_col3;

    assign req_stall = req_valid && last_step
                       && ((cnt_reg != '0) || (p_vld_reg && p_last_reg));
    assign req_acc   = req_valid && !req_stall;
    assign res_valid = (cnt_reg != '0);
    assign res_acc   = res_valid && !res_stall;
    assign load      = p_vld_reg && p_last_reg;

    assign ctl.capture  = req_acc;
    assign ctl.acc_en   = p_vld_reg;
    assign ctl.acc_last = p_last_reg;
    assign ctl.shift    = res_acc;

    always_comb
    begin
        cnt_next = cnt_reg;
        if (load)
        begin
            cnt_next = CNT_W'(CELLS);
        end
        else if (res_acc)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p_vld_reg  <= 1'b0;
            p_last_reg <= 1'b0;
            cnt_reg    <= '0;
        end
        else
        begin
            p_vld_reg  <= req_acc;
            p_last_reg <= req_acc && last_step;
            cnt_reg    <= cnt_next;
        end
    end

    assign chain_sum[CELLS] = '0;
    assign chain_sat[CELLS] = 1'b0;

    for (genvar r = 0; r < TILE; r++)
    begin : g_row
        for (genvar c = 0; c < TILE; c++)
        begin : g_col
            tomp_cell #(
                .DATA_WIDTH (DATA_WIDTH)
            ) u_cell (
                .clk           (clk),
                .rst_n         (rst_n),
                .ctl           (ctl),
                .a             (a_op[r]),
                .b             (b_op[c]),
                .chain_sum_in  (chain_sum[r*TILE+c+1]),
                .chain_sat_in  (chain_sat[r*TILE+c+1]),
                .chain_sum_out (chain_sum[r*TILE+c]),
                .chain_sat_out (chain_sat[r*TILE+c])
            );
        end
    end

    assign out_idx     = CELL_IDX_W'(CNT_W'(CELLS) - cnt_reg);
    assign tile_row    = out_idx[CELL_IDX_W-1:IDX_W];
    assign tile_col    = out_idx[IDX_W-1:0];
    assign sum_value   = chain_sum[0];
    assign saturated   = chain_sat[0];
    assign last_result = (cnt_reg == CNT_W'(1));

endmodule

`default_nettype wire
